// ----- rtl/mfu_pkg.sv -----
// Shared types and constants for the motor feedback frame unwrap block.
// Used by mfu_state and motor_feedback_frame_unwrap_top; no dependencies.
package mfu_pkg;

  typedef logic [2:0]  src_t;
  typedef logic [1:0]  reg_idx_t;
  typedef logic [10:0] can_id_t;

  localparam src_t SRC_GIMBAL   = 3'd0;
  localparam src_t SRC_CH_FRONT = 3'd1;
  localparam src_t SRC_CH_REAR  = 3'd2;
  localparam src_t SRC_PITCH    = 3'd3;
  localparam src_t SRC_FEEDER   = 3'd4;
  localparam int   NUM_SRC      = 5;

  localparam can_id_t ID_GIMBAL   = 11'h188;
  localparam can_id_t ID_CH_FRONT = 11'h201;
  localparam can_id_t ID_CH_REAR  = 11'h202;
  localparam can_id_t ID_PITCH    = 11'h206;
  localparam can_id_t ID_FEEDER   = 11'h207;

  localparam reg_idx_t REG_COUNTS_PER_TURN = 2'd0;
  localparam reg_idx_t REG_CHASSIS_THR     = 2'd1;
  localparam reg_idx_t REG_FEEDER_THR      = 2'd2;

  localparam logic [15:0] CPT_RESET         = 16'd8191;
  localparam logic [15:0] CHASSIS_THR_RESET = 16'd4096;
  localparam logic [15:0] FEEDER_THR_RESET  = 16'd4000;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 152;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = 3;

  typedef struct packed {
    logic en;
    src_t addr;
  } st_port_t;

  typedef struct packed {
    logic hit;
    src_t src;
  } src_dec_t;

  function automatic src_dec_t decode_id(input can_id_t id);
    src_dec_t d;
    d.hit = 1'b1;
    case (id)
      ID_GIMBAL:   d.src = SRC_GIMBAL;
      ID_CH_FRONT: d.src = SRC_CH_FRONT;
      ID_CH_REAR:  d.src = SRC_CH_REAR;
      ID_PITCH:    d.src = SRC_PITCH;
      ID_FEEDER:   d.src = SRC_FEEDER;
      default: begin
        d.hit = 1'b0;
        d.src = SRC_GIMBAL;
      end
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/mfu_state.sv -----
// Per-source state memory: frame count, last angle and turn count per entry.
// One write and one registered read per cycle, write-first bypass, reset via valid bits.
// Depends on mfu_pkg.
module mfu_state #(
  parameter int TW = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mfu_pkg::st_port_t rd,
  input  mfu_pkg::st_port_t wr,
  input  logic [15:0]      wr_count,
  input  logic [15:0]      wr_angle,
  input  logic [TW-1:0]    wr_turns,
  output logic [15:0]      rd_count,
  output logic [15:0]      rd_angle,
  output logic [TW-1:0]    rd_turns
);
  import mfu_pkg::*;

  localparam int EW = 32 + TW;

  logic [EW-1:0]      mem [NUM_SRC];
  logic [NUM_SRC-1:0] valid_r;
  logic [EW-1:0]      rd_data_r;
  logic [EW-1:0]      wr_data;
  logic               bypass;

  assign wr_data = {wr_turns, wr_angle, wr_count};
  assign bypass  = wr.en && (wr.addr == rd.addr);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      if (bypass) begin
        rd_data_r <= wr_data;
      end else if (valid_r[rd.addr]) begin
        rd_data_r <= mem[rd.addr];
      end else begin
        rd_data_r <= '0;
      end
    end
  end

  assign rd_count = rd_data_r[15:0];
  assign rd_angle = rd_data_r[31:16];
  assign rd_turns = rd_data_r[EW-1:32];

  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    rd.en && bypass |=> rd_data_r == $past(wr_data))
    else $error("state read missed same-cycle write");

  a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
    rd.en && !bypass && !valid_r[rd.addr] |=> rd_data_r == '0)
    else $error("unwritten state entry did not read as zero");

  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en |-> wr.addr < 3'(NUM_SRC)) and (rd.en |-> rd.addr < 3'(NUM_SRC)))
    else $error("state address out of range");

endmodule

// ----- rtl/motor_feedback_frame_unwrap_top.sv -----
// Channel | Dir | Handshake         | Payload
// in_     | in  | tvalid/tready     | tdata: frame_id, word0, word1, word2
// out_    | out | tvalid/tready     | tdata: source .. pitch_reference
// cfg_    | in  | we (no wait)      | addr, wdata
// One frame accepted per cycle while in_tready is high; a result passes through
// state read, read-modify-write, multiply and an add into the output queue.
// Full rate: the state memory takes one read and one write per cycle, with a
// write-first bypass when back-to-back items hit the same source.
// in_tready drops when in-flight items plus queued results reach 8.
// Reset (rst_n low, synchronous) clears state valid bits and queue, and loads config reset values.
// Depends on mfu_pkg and mfu_state.
module motor_feedback_frame_unwrap_top #(
  parameter int TURN_COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // frame_id[10:0], word0[26:11], word1[42:27], word2[58:43], zero pad
  input  logic [63:0]            in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // source[2:0], raw_angle[18:3], speed[34:19], torque_current[50:35],
  // position[82:51], frame_count[98:83], motion_mode[114:99],
  // speed_command[130:115], pitch_reference[146:131], zero pad
  output logic [151:0]           out_tdata,
  input  logic                   cfg_we,
  input  mfu_pkg::reg_idx_t      cfg_addr,
  input  logic [15:0]            cfg_wdata
);
  import mfu_pkg::*;

  localparam int TW = TURN_COUNT_WIDTH;
  localparam int PW = 17 + TW;

  // configuration
  logic [15:0] cpt_r, chassis_thr_r, feeder_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpt_r         <= CPT_RESET;
      chassis_thr_r <= CHASSIS_THR_RESET;
      feeder_thr_r  <= FEEDER_THR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COUNTS_PER_TURN: cpt_r         <= cfg_wdata;
        REG_CHASSIS_THR:     chassis_thr_r <= cfg_wdata;
        REG_FEEDER_THR:      feeder_thr_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // accept and decode
  logic     in_fire;
  src_dec_t dec;
  st_port_t rd_port, wr_port;

  assign in_fire = in_tvalid && in_tready;
  assign dec     = decode_id(in_tdata[10:0]);
  assign rd_port = '{en: in_fire && dec.hit, addr: dec.src};

  // stage 1: state read data valid, update
  logic        s1_v_r;
  src_t        s1_src_r;
  logic [15:0] s1_w0_r, s1_w1_r, s1_w2_r;
  logic [15:0] rd_count, rd_angle, wr_count, wr_angle;
  logic [TW-1:0] rd_turns, wr_turns;
  logic [15:0] thr;
  logic signed [17:0] diff, thr_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= rd_port.en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_port.en) begin
      s1_src_r <= dec.src;
      s1_w0_r  <= in_tdata[26:11];
      s1_w1_r  <= in_tdata[42:27];
      s1_w2_r  <= in_tdata[58:43];
    end
  end

  always_comb begin
    thr      = (s1_src_r == SRC_FEEDER) ? feeder_thr_r : chassis_thr_r;
    thr_s    = $signed({2'b00, thr});
    diff     = $signed({2'b00, s1_w0_r}) - $signed({2'b00, rd_angle});
    wr_count = rd_count + 16'd1;
    wr_angle = rd_angle;
    wr_turns = rd_turns;
    if (s1_src_r inside {SRC_CH_FRONT, SRC_CH_REAR, SRC_FEEDER}) begin
      wr_angle = s1_w0_r;
      if (diff > thr_s) begin
        wr_turns = rd_turns - TW'(1);
      end else if (diff < -thr_s) begin
        wr_turns = rd_turns + TW'(1);
      end
    end
  end

  assign wr_port = '{en: s1_v_r, addr: s1_src_r};

  mfu_state #(.TW(TW)) u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd       (rd_port),
    .wr       (wr_port),
    .wr_count (wr_count),
    .wr_angle (wr_angle),
    .wr_turns (wr_turns),
    .rd_count (rd_count),
    .rd_angle (rd_angle),
    .rd_turns (rd_turns)
  );

  // stage 2: multiply
  logic          s2_v_r;
  src_t          s2_src_r;
  logic [15:0]   s2_w0_r, s2_w1_r, s2_w2_r, s2_count_r;
  logic [TW-1:0] s2_turns_r;
  logic signed [PW-1:0] prod_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_src_r   <= s1_src_r;
      s2_w0_r    <= s1_w0_r;
      s2_w1_r    <= s1_w1_r;
      s2_w2_r    <= s1_w2_r;
      s2_count_r <= wr_count;
      s2_turns_r <= wr_turns;
    end
  end

  assign prod_full = $signed({1'b0, cpt_r}) * $signed(s2_turns_r);

  // stage 3: add and assemble
  logic        s3_v_r;
  src_t        s3_src_r;
  logic [15:0] s3_w0_r, s3_w1_r, s3_w2_r, s3_count_r;
  logic [31:0] s3_prod_r;
  logic [OUT_TDATA_W-1:0] res_word;
  logic [15:0] f_raw, f_speed, f_torque, f_mode, f_cmd, f_ref;
  logic [31:0] f_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      s3_src_r   <= s2_src_r;
      s3_w0_r    <= s2_w0_r;
      s3_w1_r    <= s2_w1_r;
      s3_w2_r    <= s2_w2_r;
      s3_count_r <= s2_count_r;
      s3_prod_r  <= 32'(prod_full);
    end
  end

  always_comb begin
    f_raw    = '0;
    f_speed  = '0;
    f_torque = '0;
    f_pos    = '0;
    f_mode   = '0;
    f_cmd    = '0;
    f_ref    = '0;
    case (s3_src_r)
      SRC_GIMBAL: begin
        f_mode = s3_w0_r;
        f_cmd  = s3_w1_r;
        f_ref  = s3_w2_r;
      end
      SRC_PITCH: begin
        f_raw    = s3_w0_r;
        f_speed  = s3_w1_r;
        f_torque = s3_w2_r;
        f_pos    = {16'd0, s3_w0_r};
      end
      SRC_CH_FRONT, SRC_CH_REAR, SRC_FEEDER: begin
        f_raw   = s3_w0_r;
        f_speed = s3_w1_r;
        f_pos   = {16'd0, s3_w0_r} + s3_prod_r;
      end
      default: ;
    endcase
    res_word = {5'd0, f_ref, f_cmd, f_mode, s3_count_r, f_pos, f_torque, f_speed, f_raw,
                s3_src_r};
  end

  // result queue
  logic [OUT_TDATA_W-1:0] fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head_r, tail_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               push, pop;
  logic [FIFO_AW:0]   occ;

  assign push = s3_v_r;
  assign pop  = out_tvalid && out_tready;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        tail_r <= tail_r + 1'b1;
      end
      if (pop) begin
        head_r <= head_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[tail_r] <= res_word;
    end
  end

  assign occ        = cnt_r + (FIFO_AW+1)'(s1_v_r) + (FIFO_AW+1)'(s2_v_r)
                      + (FIFO_AW+1)'(s3_v_r);
  assign in_tready  = occ < (FIFO_AW+1)'(FIFO_DEPTH);
  assign out_tvalid = cnt_r != '0;
  assign out_tdata  = fifo_mem[head_r];

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("in-flight items exceed queue space");

  a_ignore_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !dec.hit |=> !s1_v_r)
    else $error("unknown identifier entered the pipeline");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != (FIFO_AW+1)'(FIFO_DEPTH)) || pop)
    else $error("result queue overflow");

endmodule
